>>> rtl/mss_pkg.sv
// Shared types and constants for the motion segment statistics block.
// Used by mss_ctrl, mss_datapath and motion_segment_stats.
`timescale 1ns / 1ps

package mss_pkg;

   localparam int COORD_W   = 16;
   localparam int SLOW_W    = 8;
   localparam int SPEED_W   = 16;
   localparam int ACC_W     = 32;
   localparam int DT_W      = 20;
   localparam int ROOT_W    = 17;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int NUM_W     = 30;
   localparam int CNT_W     = 5;
   localparam int ONE_Q14   = 16384;

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_MOTION  = 2'd1;
   localparam logic [1:0] MODE_STOPPED = 2'd2;

   localparam logic CSR_SPEED_THRESHOLD  = 1'b0;
   localparam logic CSR_STOP_FRAME_COUNT = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_VSQ_A,
      OP_VSQ_B,
      OP_DSQ_A,
      OP_DSQ_B,
      OP_ROOT_STEP,
      OP_SPEED,
      OP_DIST,
      OP_OFF_B,
      OP_DIVX_INIT,
      OP_DIVY_INIT,
      OP_DIV_STEP,
      OP_COMMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic sample_valid;
      logic path_en;
      logic launch;
      logic iter_last;
   } status_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic                      segment_done;
      logic [15:0]               segment_number;
      logic [SPEED_W-1:0]        speed_now;
      logic [SPEED_W-1:0]        start_speed;
      logic [SPEED_W-1:0]        top_speed;
      logic [ACC_W-1:0]          path_length;
      logic [SPEED_W-1:0]        max_offset;
      logic [ACC_W-1:0]          motion_time_us;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } stats_type;

endpackage

>>> rtl/mss_ctrl.sv
// Sequencer for the motion segment statistics block.
// Issues datapath commands per sample; depends on mss_pkg.
`timescale 1ns / 1ps

module mss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               out_free,
   input  mss_pkg::status_type status,
   output mss_pkg::cmd_type    cmd,
   output logic               idle,
   output logic               out_load
);

   typedef enum logic [16:0] {
      S_IDLE   = 17'b00000000000000001,
      S_VSQA   = 17'b00000000000000010,
      S_VSQB   = 17'b00000000000000100,
      S_VROOT  = 17'b00000000000001000,
      S_VSET   = 17'b00000000000010000,
      S_DSQA   = 17'b00000000000100000,
      S_DSQB   = 17'b00000000001000000,
      S_DROOT  = 17'b00000000010000000,
      S_DSET   = 17'b00000000100000000,
      S_OFF    = 17'b00000001000000000,
      S_BRANCH = 17'b00000010000000000,
      S_DIVXI  = 17'b00000100000000000,
      S_DIVX   = 17'b00001000000000000,
      S_DIVYI  = 17'b00010000000000000,
      S_DIVY   = 17'b00100000000000000,
      S_COMMIT = 17'b01000000000000000,
      S_FINISH = 17'b10000000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = mss_pkg::OP_NONE;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = mss_pkg::OP_LOAD;
               state_in = S_VSQA;
            end
         end
         S_VSQA: begin
            cmd.op   = mss_pkg::OP_VSQ_A;
            state_in = status.sample_valid ? S_VSQB : S_COMMIT;
         end
         S_VSQB: begin
            cmd.op   = mss_pkg::OP_VSQ_B;
            state_in = S_VROOT;
         end
         S_VROOT: begin
            cmd.op = mss_pkg::OP_ROOT_STEP;
            if (status.iter_last) state_in = S_VSET;
         end
         S_VSET: begin
            cmd.op   = mss_pkg::OP_SPEED;
            state_in = status.path_en ? S_DSQA : S_BRANCH;
         end
         S_DSQA: begin
            cmd.op   = mss_pkg::OP_DSQ_A;
            state_in = S_DSQB;
         end
         S_DSQB: begin
            cmd.op   = mss_pkg::OP_DSQ_B;
            state_in = S_DROOT;
         end
         S_DROOT: begin
            cmd.op = mss_pkg::OP_ROOT_STEP;
            if (status.iter_last) state_in = S_DSET;
         end
         S_DSET: begin
            cmd.op   = mss_pkg::OP_DIST;
            state_in = S_OFF;
         end
         S_OFF: begin
            cmd.op   = mss_pkg::OP_OFF_B;
            state_in = S_BRANCH;
         end
         S_BRANCH: begin
            state_in = status.launch ? S_DIVXI : S_COMMIT;
         end
         S_DIVXI: begin
            cmd.op   = mss_pkg::OP_DIVX_INIT;
            state_in = S_DIVX;
         end
         S_DIVX: begin
            cmd.op = mss_pkg::OP_DIV_STEP;
            if (status.iter_last) state_in = S_DIVYI;
         end
         S_DIVYI: begin
            cmd.op   = mss_pkg::OP_DIVY_INIT;
            state_in = S_DIVY;
         end
         S_DIVY: begin
            cmd.op = mss_pkg::OP_DIV_STEP;
            if (status.iter_last) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.op   = mss_pkg::OP_COMMIT;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign idle = (state_ff == S_IDLE);

endmodule

>>> rtl/mss_datapath.sv
// Datapath: sample registers, shared square root and divider, segment state.
// Driven by mss_ctrl commands; depends on mss_pkg.
`timescale 1ns / 1ps

module mss_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mss_pkg::cmd_type                      cmd,
   input  logic                                  in_valid,
   input  logic signed [mss_pkg::COORD_W-1:0]    in_pos_x,
   input  logic signed [mss_pkg::COORD_W-1:0]    in_pos_y,
   input  logic signed [mss_pkg::COORD_W-1:0]    in_vel_x,
   input  logic signed [mss_pkg::COORD_W-1:0]    in_vel_y,
   input  logic [mss_pkg::DT_W-1:0]              in_dt,
   input  logic [mss_pkg::SPEED_W-1:0]           speed_threshold,
   input  logic [7:0]                            stop_frame_count,
   output mss_pkg::status_type                   status,
   output mss_pkg::stats_type                    stats
);

   localparam int CW = mss_pkg::COORD_W;
   localparam int RW = mss_pkg::ROOT_W;
   localparam int AW = mss_pkg::RAD_W;
   localparam int NW = mss_pkg::NUM_W;
   localparam int SW = mss_pkg::SPEED_W;
   localparam int XW = mss_pkg::ACC_W;
   localparam int KW = mss_pkg::CNT_W;
   localparam int LW = mss_pkg::SLOW_W;

   function automatic logic [RW-1:0] mag17(input logic signed [RW-1:0] v);
      mag17 = v[RW-1] ? RW'(-v) : RW'(v);
   endfunction

   // latched sample
   logic                 valid_ff;
   logic signed [CW-1:0] px_ff, py_ff, vx_ff, vy_ff;
   logic [mss_pkg::DT_W-1:0] dt_ff;

   // arithmetic temporaries
   logic [AW-1:0]        sq_ff, rad_ff;
   logic [RW+1:0]        rem_ff;
   logic [RW-1:0]        root_ff;
   logic [KW-1:0]        cnt_ff;
   logic [NW-1:0]        num_ff, quo_ff;
   logic [SW:0]          drem_ff;
   logic [SW-1:0]        spd_ff;
   logic [RW-1:0]        dist_ff;
   logic signed [2*RW-2:0] prod_ff;
   logic [SW-1:0]        off_ff;
   logic signed [CW-1:0] ux_tmp_ff;

   // architectural state
   logic [1:0]           mode_ff;
   logic                 prev_valid_ff, dir_valid_ff, done_ff;
   logic signed [CW-1:0] prev_x_ff, prev_y_ff, udx_ff, udy_ff;
   logic signed [CW-1:0] origin_x_ff, origin_y_ff, last_x_ff, last_y_ff;
   logic [LW-1:0]        slow_ff;
   logic [15:0]          done_count_ff;
   logic [SW-1:0]        speed_latest_ff, launch_ff, peak_ff, offset_max_ff;
   logic [XW-1:0]        length_ff, time_ff;

   logic [RW-1:0]        mvx, mvy, mdx, mdy;
   logic [RW+1:0]        rem_sh, trial;
   logic                 root_ge;
   logic [SW:0]          drem_sh;
   logic                 div_ge;
   logic signed [RW-1:0] rx, ry;
   logic signed [2*RW-1:0] cross_val;
   logic [2*RW-1:0]      cross_mag;
   logic [2*RW-14:0]     off_round;
   logic [NW-1:0]        q_clamp;
   logic signed [CW-1:0] q_signed;
   logic [XW:0]          len_sum, time_sum;
   logic [LW-1:0]        slow_inc;

   always_comb begin
      mvx = mag17(RW'(vx_ff));
      mvy = mag17(RW'(vy_ff));
      mdx = mag17(RW'(px_ff) - RW'(prev_x_ff));
      mdy = mag17(RW'(py_ff) - RW'(prev_y_ff));

      rem_sh  = {rem_ff[RW-1:0], rad_ff[AW-1 -: 2]};
      trial   = {root_ff, 2'b01};
      root_ge = (rem_sh >= trial);

      drem_sh = {drem_ff[SW-1:0], num_ff[NW-1]};
      div_ge  = (drem_sh >= {1'b0, spd_ff});

      rx        = RW'(px_ff) - RW'(origin_x_ff);
      ry        = RW'(py_ff) - RW'(origin_y_ff);
      cross_val = (2*RW)'(prod_ff) - ((2*RW)'(ry) * (2*RW)'(udx_ff));
      cross_mag = cross_val[2*RW-1] ? (2*RW)'(-cross_val) : (2*RW)'(cross_val);
      off_round = (2*RW-13)'((cross_mag + (2*RW)'(8192)) >> 14);

      q_clamp  = (quo_ff > NW'(mss_pkg::ONE_Q14)) ? NW'(mss_pkg::ONE_Q14) : quo_ff;

      len_sum  = {1'b0, length_ff} + (XW+1)'(dist_ff);
      time_sum = {1'b0, time_ff} + (XW+1)'(dt_ff);
      slow_inc = (slow_ff == {LW{1'b1}}) ? slow_ff : slow_ff + LW'(1);
   end

   always_comb begin
      q_signed = CW'(q_clamp);
      if (cmd.op == mss_pkg::OP_DIVY_INIT) begin
         if (vx_ff[CW-1]) q_signed = -CW'(q_clamp);
      end else begin
         if (vy_ff[CW-1]) q_signed = -CW'(q_clamp);
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         mss_pkg::OP_LOAD: begin
            valid_ff <= in_valid;
            px_ff    <= in_pos_x;
            py_ff    <= in_pos_y;
            vx_ff    <= in_vel_x;
            vy_ff    <= in_vel_y;
            dt_ff    <= in_dt;
         end
         mss_pkg::OP_VSQ_A: sq_ff <= AW'(mvx) * AW'(mvx);
         mss_pkg::OP_DSQ_A: sq_ff <= AW'(mdx) * AW'(mdx);
         mss_pkg::OP_VSQ_B, mss_pkg::OP_DSQ_B: begin
            rad_ff  <= sq_ff + ((cmd.op == mss_pkg::OP_VSQ_B) ? AW'(mvy) * AW'(mvy)
                                                             : AW'(mdy) * AW'(mdy));
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= KW'(NW - RW);
         end
         mss_pkg::OP_ROOT_STEP: begin
            rad_ff  <= {rad_ff[AW-3:0], 2'b00};
            rem_ff  <= root_ge ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[RW-2:0], root_ge};
            cnt_ff  <= cnt_ff + KW'(1);
         end
         mss_pkg::OP_SPEED: spd_ff <= root_ff[RW-1] ? {SW{1'b1}} : root_ff[SW-1:0];
         mss_pkg::OP_DIST: begin
            dist_ff <= root_ff;
            prod_ff <= (2*RW-1)'(rx) * (2*RW-1)'(udy_ff);
         end
         mss_pkg::OP_OFF_B: begin
            off_ff <= (|off_round[2*RW-14:SW]) ? {SW{1'b1}} : off_round[SW-1:0];
         end
         mss_pkg::OP_DIVX_INIT, mss_pkg::OP_DIVY_INIT: begin
            if (cmd.op == mss_pkg::OP_DIVY_INIT) ux_tmp_ff <= q_signed;
            num_ff  <= NW'({((cmd.op == mss_pkg::OP_DIVX_INIT) ? mvx : mvy), 14'b0})
                       + NW'(spd_ff >> 1);
            drem_ff <= '0;
            quo_ff  <= '0;
            cnt_ff  <= '0;
         end
         mss_pkg::OP_DIV_STEP: begin
            num_ff  <= {num_ff[NW-2:0], 1'b0};
            drem_ff <= div_ge ? drem_sh - {1'b0, spd_ff} : drem_sh;
            quo_ff  <= {quo_ff[NW-2:0], div_ge};
            cnt_ff  <= cnt_ff + KW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= mss_pkg::MODE_IDLE;
         prev_valid_ff   <= 1'b0;
         prev_x_ff       <= '0;
         prev_y_ff       <= '0;
         dir_valid_ff    <= 1'b0;
         udx_ff          <= '0;
         udy_ff          <= '0;
         slow_ff         <= '0;
         done_count_ff   <= '0;
         speed_latest_ff <= '0;
         launch_ff       <= '0;
         peak_ff         <= '0;
         length_ff       <= '0;
         offset_max_ff   <= '0;
         time_ff         <= '0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         last_x_ff       <= '0;
         last_y_ff       <= '0;
         done_ff         <= 1'b0;
      end else if (cmd.op == mss_pkg::OP_COMMIT) begin
         done_ff <= 1'b0;
         if (!valid_ff) begin
            prev_valid_ff <= 1'b0;
         end else begin
            speed_latest_ff <= spd_ff;
            prev_x_ff       <= px_ff;
            prev_y_ff       <= py_ff;
            prev_valid_ff   <= 1'b1;
            if (status.path_en) begin
               length_ff <= len_sum[XW] ? {XW{1'b1}} : len_sum[XW-1:0];
               time_ff   <= time_sum[XW] ? {XW{1'b1}} : time_sum[XW-1:0];
               if (spd_ff > peak_ff) peak_ff <= spd_ff;
               if (dir_valid_ff && off_ff > offset_max_ff) offset_max_ff <= off_ff;
               last_x_ff <= px_ff;
               last_y_ff <= py_ff;
            end
            if (mode_ff == mss_pkg::MODE_MOTION) begin
               if (spd_ff < speed_threshold) begin
                  slow_ff <= slow_inc;
                  if (16'(slow_inc) >= 16'(stop_frame_count)) begin
                     mode_ff <= mss_pkg::MODE_STOPPED;
                     if (done_count_ff != 16'hFFFF) done_count_ff <= done_count_ff + 16'd1;
                     done_ff <= 1'b1;
                  end
               end else begin
                  slow_ff <= '0;
               end
            end else if (status.launch) begin
               mode_ff       <= mss_pkg::MODE_MOTION;
               launch_ff     <= spd_ff;
               peak_ff       <= spd_ff;
               length_ff     <= '0;
               offset_max_ff <= '0;
               time_ff       <= '0;
               origin_x_ff   <= px_ff;
               origin_y_ff   <= py_ff;
               last_x_ff     <= px_ff;
               last_y_ff     <= py_ff;
               udx_ff        <= ux_tmp_ff;
               udy_ff        <= q_signed;
               dir_valid_ff  <= (spd_ff != '0);
               slow_ff       <= '0;
            end
         end
      end
   end

   always_comb begin
      status.sample_valid = valid_ff;
      status.path_en      = prev_valid_ff && (mode_ff == mss_pkg::MODE_MOTION);
      status.launch       = (mode_ff != mss_pkg::MODE_MOTION) && (spd_ff > speed_threshold);
      status.iter_last    = (cnt_ff == KW'(NW - 1));

      stats.mode         = mode_ff;
      stats.segment_done = done_ff;
      unique case (mode_ff)
         mss_pkg::MODE_MOTION:
            stats.segment_number = (done_count_ff != 16'hFFFF) ? done_count_ff + 16'd1
                                                              : 16'hFFFF;
         mss_pkg::MODE_STOPPED: stats.segment_number = done_count_ff;
         default:               stats.segment_number = 16'd0;
      endcase
      stats.speed_now      = speed_latest_ff;
      stats.start_speed    = launch_ff;
      stats.top_speed      = peak_ff;
      stats.path_length    = length_ff;
      stats.max_offset     = offset_max_ff;
      stats.motion_time_us = time_ff;
      stats.end_x          = last_x_ff;
      stats.end_y          = last_y_ff;
   end

endmodule

>>> rtl/motion_segment_stats.sv
// Top level of the motion segment statistics block: stream ports, CSRs, result register.
// Instantiates mss_ctrl and mss_datapath; depends on mss_pkg.
`timescale 1ns / 1ps

// Takes one tracked-object sample word per frame and returns one statistics word for
// it. A valid sample runs a bit-pair square root of 17 steps for its speed; while a
// segment is running a second one finds the distance, and a launch adds two 30-step
// restoring divisions. All of them share one counter. An invalid sample skips them.
// One sample is in work at a time; the next is taken as soon as the result sits in
// the output register, even if not yet taken.
module motion_segment_stats (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[15:0], pos_y[31:16], vel_x[47:32], vel_y[63:48], frame_time_us[83:64]
   input  logic [87:0]  req_tdata,
   // sample_valid[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mode[1:0], segment_number[17:2], speed_now[33:18], start speed[49:34],
   // top speed[65:50], path_length[97:66], max_offset[113:98],
   // motion_time_us[145:114], end_x[161:146], end_y[177:162]
   output logic [183:0] rsp_tdata,
   // segment_done
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   mss_pkg::cmd_type    cmd;
   mss_pkg::status_type status;
   mss_pkg::stats_type  stats;

   logic        idle, out_load, out_free, start;
   logic [15:0] thr_ff;
   logic [7:0]  stop_ff;
   logic        rsp_valid_ff;
   logic [183:0] rsp_data_ff;
   logic        rsp_last_ff;

   assign csr_pready = 1'b1;
   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= 16'd32;
         stop_ff <= 8'd5;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            mss_pkg::CSR_SPEED_THRESHOLD:  thr_ff  <= csr_pwdata[15:0];
            mss_pkg::CSR_STOP_FRAME_COUNT: stop_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         mss_pkg::CSR_SPEED_THRESHOLD:  csr_prdata = {16'd0, thr_ff};
         mss_pkg::CSR_STOP_FRAME_COUNT: csr_prdata = {24'd0, stop_ff};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   mss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .status   (status),
      .cmd      (cmd),
      .idle     (idle),
      .out_load (out_load)
   );

   mss_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .in_valid         (req_tuser),
      .in_pos_x         (req_tdata[15:0]),
      .in_pos_y         (req_tdata[31:16]),
      .in_vel_x         (req_tdata[47:32]),
      .in_vel_y         (req_tdata[63:48]),
      .in_dt            (req_tdata[83:64]),
      .speed_threshold  (thr_ff),
      .stop_frame_count (stop_ff),
      .status           (status),
      .stats            (stats)
   );

   always_ff @(posedge clock) begin
      if (reset)                       rsp_valid_ff <= 1'b0;
      else if (out_load)               rsp_valid_ff <= 1'b1;
      else if (rsp_tready)             rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_last_ff <= stats.segment_done;
         rsp_data_ff <= {6'd0, stats.end_y, stats.end_x, stats.motion_time_us,
                         stats.max_offset, stats.path_length, stats.top_speed,
                         stats.start_speed, stats.speed_now, stats.segment_number,
                         stats.mode};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_done_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[1:0] == mss_pkg::MODE_STOPPED)
      else $error("segment_done without stopped mode");
   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("illegal mode code");
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in work");
`endif

endmodule
